// ===== hw/rtl/qcac_pkg.sv =====
// Package for the quad attitude controller: widths, limits, register codes, types.
`default_nettype none
package qcac_pkg;

  localparam int unsigned MulW  = 21;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 20;

  localparam logic signed [16:0] THR_MIN    = -17'sd3277;
  localparam logic signed [16:0] THR_MAX    = 17'sd32768;
  localparam logic signed [16:0] THR_ACTIVE = 17'sd32;
  localparam logic signed [16:0] MANUAL_LOW = 17'sd1638;
  localparam logic signed [15:0] ERR_CLIP   = 16'sd4480;

  localparam logic [15:0] ANGLE_GAIN_RST     = 16'd1536;
  localparam logic [15:0] INTEGRAL_GAIN_RST  = 16'd6554;
  localparam logic [14:0] INTEGRAL_LIMIT_RST = 15'd800;
  localparam logic [13:0] CLEAR_BAND_RST     = 14'd19;
  localparam logic [19:0] PITCH_GAIN_RST     = 20'd23488;
  localparam logic [19:0] ROLL_GAIN_RST      = 20'd23488;
  localparam logic [19:0] YAW_GAIN_RST       = 20'd77175;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ANGLE_GAIN     = 4'd0,
    REG_INTEGRAL_GAIN  = 4'd1,
    REG_INTEGRAL_LIMIT = 4'd2,
    REG_CLEAR_BAND     = 4'd3,
    REG_PITCH_GAIN     = 4'd4,
    REG_ROLL_GAIN      = 4'd5,
    REG_YAW_GAIN       = 4'd6,
    REG_MANUAL_SELECT  = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] angle_gain;
    logic [15:0] integral_gain;
    logic [14:0] integral_limit;
    logic [13:0] clear_band;
    logic [19:0] pitch_rate_gain;
    logic [19:0] roll_rate_gain;
    logic [19:0] yaw_rate_gain;
    logic        manual_select;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_M7,
    S_MIX
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/quad_cascaded_attitude_controller.sv =====
// Cascaded angle PI / rate P attitude controller with X-quad mixer, top level.
// Controller mode: after the request is accepted, errors are formed and seven products
// go in turn through one 21x21 multiplier before the mixer loads the result.
// Manual mode: the multiplier steps are skipped. A new request is taken only in idle.
// A finished result waits in the output register while the next request runs.
// Reset (synchronous, rst_n low): registers to defaults, integrators zero, no result.
`default_nettype none
module quad_cascaded_attitude_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [14:0]            in_pitch_angle,
  input  wire logic signed [14:0]            in_roll_angle,
  input  wire logic signed [15:0]            in_pitch_rate,
  input  wire logic signed [15:0]            in_roll_rate,
  input  wire logic signed [15:0]            in_yaw_rate,
  input  wire logic signed [14:0]            in_pitch_target,
  input  wire logic signed [14:0]            in_roll_target,
  input  wire logic signed [15:0]            in_yaw_rate_target,
  input  wire logic signed [16:0]            in_throttle,
  input  wire logic                          in_armed_flag,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [16:0]                 out_motor_one,
  output logic signed [16:0]                 out_motor_two,
  output logic signed [16:0]                 out_motor_three,
  output logic signed [16:0]                 out_motor_four,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [qcac_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [qcac_pkg::CfgDataW-1:0] cfg_data
);

  localparam int unsigned MW = qcac_pkg::MulW;
  localparam int unsigned PW = qcac_pkg::ProdW;

  qcac_pkg::cfg_regs_t regs;
  qcac_pkg::state_t    state_r, state_nxt;

  // captured request
  logic signed [14:0] pa_r, ra_r, pt_r, rt_r;
  logic signed [15:0] pr_r, rr_r, yr_r, yt_r;
  logic signed [16:0] thr_r;
  logic               armed_r;

  // working registers
  logic signed [13:0] pe_r, re_r;
  logic signed [16:0] ydiff_r;
  logic signed [16:0] t_r;
  logic               grow_r;
  logic signed [15:0] pint_r, rint_r;
  logic signed [20:0] pdiff_r, rdiff_r;
  logic signed [27:0] vp_r, vr_r, vy_r;

  logic               out_valid_r;
  logic signed [16:0] m1_r, m2_r, m3_r, m4_r;

  logic                 mul_en;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  logic signed [15:0] pe_full, re_full;
  logic signed [16:0] t_ctrl, t_man;
  logic signed [PW-1:0] rnd10, rnd13;
  logic signed [20:0] p_term;
  logic signed [27:0] axis_v;
  logic               load_out;

  qcac_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  qcac_mul u_mul (
    .clk   (clk),
    .en    (mul_en),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == qcac_pkg::S_IDLE);

  function automatic logic signed [13:0] clip_err(input logic signed [15:0] e);
    logic signed [15:0] c;
    c = e;
    if (e > qcac_pkg::ERR_CLIP) c = qcac_pkg::ERR_CLIP;
    else if (e < -qcac_pkg::ERR_CLIP) c = -qcac_pkg::ERR_CLIP;
    return c[13:0];
  endfunction

  function automatic logic signed [15:0] integ_upd(
    input logic signed [PW-1:0] p,
    input logic signed [15:0]   integ,
    input logic signed [13:0]   err,
    input logic                 grow,
    input logic [14:0]          lim,
    input logic [13:0]          band
  );
    logic signed [PW-1:0] rnd;
    logic signed [16:0]   step;
    logic signed [16:0]   acc;
    logic [13:0]          mag;
    logic signed [16:0]   lim_s;
    rnd   = (p + PW'(131072)) >>> 18;
    step  = rnd[16:0];
    acc   = grow ? (17'(integ) + step) : 17'sd0;
    mag   = err[13] ? 14'(-err) : err;
    if (mag < band) acc = 17'sd0;
    lim_s = $signed({2'b00, lim});
    if (acc > lim_s) acc = lim_s;
    else if (acc < -lim_s) acc = -lim_s;
    return acc[15:0];
  endfunction

  function automatic logic signed [16:0] clamp_motor(input logic signed [29:0] s);
    logic signed [16:0] c;
    c = s[16:0];
    if (s > 30'(qcac_pkg::THR_MAX)) c = qcac_pkg::THR_MAX;
    else if (s < 30'(qcac_pkg::THR_MIN)) c = qcac_pkg::THR_MIN;
    return c;
  endfunction

  // front-end arithmetic for the error step
  always_comb begin
    pe_full = 16'(pt_r) - 16'(pa_r);
    re_full = 16'(rt_r) - 16'(ra_r);
    t_ctrl  = thr_r;
    if (thr_r < qcac_pkg::THR_MIN) t_ctrl = qcac_pkg::THR_MIN;
    else if (thr_r > qcac_pkg::THR_MAX) t_ctrl = qcac_pkg::THR_MAX;
    t_man = (thr_r > qcac_pkg::THR_MAX) ? qcac_pkg::THR_MAX : thr_r;
    if (t_man <= qcac_pkg::MANUAL_LOW) t_man = qcac_pkg::THR_MIN;
  end

  // product post-processing
  always_comb begin
    rnd10  = (prod + PW'(512)) >>> 10;
    rnd13  = (prod + PW'(4096)) >>> 13;
    p_term = rnd10[20:0];
    axis_v = rnd13[27:0];
  end

  // sequencer: next state and multiplier operand select
  always_comb begin
    state_nxt = state_r;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    load_out  = 1'b0;
    case (state_r)
      qcac_pkg::S_IDLE: if (in_valid) state_nxt = qcac_pkg::S_ERR;
      qcac_pkg::S_ERR:  state_nxt = regs.manual_select ? qcac_pkg::S_MIX : qcac_pkg::S_M0;
      qcac_pkg::S_M0: begin
        mul_en = 1'b1; mul_a = MW'(pe_r); mul_b = $signed({5'b0, regs.integral_gain});
        state_nxt = qcac_pkg::S_M1;
      end
      qcac_pkg::S_M1: begin
        mul_en = 1'b1; mul_a = MW'(re_r); mul_b = $signed({5'b0, regs.integral_gain});
        state_nxt = qcac_pkg::S_M2;
      end
      qcac_pkg::S_M2: begin
        mul_en = 1'b1; mul_a = MW'(pe_r); mul_b = $signed({5'b0, regs.angle_gain});
        state_nxt = qcac_pkg::S_M3;
      end
      qcac_pkg::S_M3: begin
        mul_en = 1'b1; mul_a = MW'(re_r); mul_b = $signed({5'b0, regs.angle_gain});
        state_nxt = qcac_pkg::S_M4;
      end
      qcac_pkg::S_M4: begin
        mul_en = 1'b1; mul_a = pdiff_r; mul_b = $signed({1'b0, regs.pitch_rate_gain});
        state_nxt = qcac_pkg::S_M5;
      end
      qcac_pkg::S_M5: begin
        mul_en = 1'b1; mul_a = rdiff_r; mul_b = $signed({1'b0, regs.roll_rate_gain});
        state_nxt = qcac_pkg::S_M6;
      end
      qcac_pkg::S_M6: begin
        mul_en = 1'b1; mul_a = MW'(ydiff_r); mul_b = $signed({1'b0, regs.yaw_rate_gain});
        state_nxt = qcac_pkg::S_M7;
      end
      qcac_pkg::S_M7: state_nxt = qcac_pkg::S_MIX;
      qcac_pkg::S_MIX: begin
        // hold here until the previous result has been taken
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = qcac_pkg::S_IDLE;
        end
      end
      default: state_nxt = qcac_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= qcac_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // integrators are control state and clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pint_r <= '0;
      rint_r <= '0;
    end else if (state_r == qcac_pkg::S_M1) begin
      pint_r <= integ_upd(prod, pint_r, pe_r, grow_r, regs.integral_limit, regs.clear_band);
    end else if (state_r == qcac_pkg::S_M2) begin
      rint_r <= integ_upd(prod, rint_r, re_r, grow_r, regs.integral_limit, regs.clear_band);
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state_r)
      qcac_pkg::S_IDLE: begin
        if (in_valid) begin
          pa_r    <= in_pitch_angle;
          ra_r    <= in_roll_angle;
          pr_r    <= in_pitch_rate;
          rr_r    <= in_roll_rate;
          yr_r    <= in_yaw_rate;
          pt_r    <= in_pitch_target;
          rt_r    <= in_roll_target;
          yt_r    <= in_yaw_rate_target;
          thr_r   <= in_throttle;
          armed_r <= in_armed_flag;
        end
      end
      qcac_pkg::S_ERR: begin
        pe_r    <= clip_err(pe_full);
        re_r    <= clip_err(re_full);
        ydiff_r <= 17'(yt_r) - 17'(yr_r);
        grow_r  <= armed_r && (t_ctrl > qcac_pkg::THR_ACTIVE);
        if (regs.manual_select) begin
          // manual: mixer sees zero axis terms, so all motors get t
          t_r  <= t_man;
          vp_r <= '0;
          vr_r <= '0;
          vy_r <= '0;
        end else begin
          t_r <= t_ctrl;
        end
      end
      qcac_pkg::S_M3: pdiff_r <= p_term + 21'(pint_r) - 21'(pr_r);
      qcac_pkg::S_M4: rdiff_r <= p_term + 21'(rint_r) - 21'(rr_r);
      qcac_pkg::S_M5: vp_r <= axis_v;
      qcac_pkg::S_M6: vr_r <= axis_v;
      qcac_pkg::S_M7: vy_r <= axis_v;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m1_r <= clamp_motor(30'(t_r) + 30'(vp_r) + 30'(vr_r) + 30'(vy_r));
      m2_r <= clamp_motor(30'(t_r) + 30'(vp_r) - 30'(vr_r) - 30'(vy_r));
      m3_r <= clamp_motor(30'(t_r) - 30'(vp_r) - 30'(vr_r) + 30'(vy_r));
      m4_r <= clamp_motor(30'(t_r) - 30'(vp_r) + 30'(vr_r) - 30'(vy_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        out_valid_r <= 1'b0;
    else if (load_out) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  assign out_valid       = out_valid_r;
  assign out_motor_one   = m1_r;
  assign out_motor_two   = m2_r;
  assign out_motor_three = m3_r;
  assign out_motor_four  = m4_r;

  a_rise_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == qcac_pkg::S_MIX))
    else $error("result raised outside the mix step");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == qcac_pkg::S_ERR))
    else $error("accepted request did not start the sequence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(m1_r) && $stable(m4_r)))
    else $error("pending result overwritten");

  a_motor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (m1_r >= qcac_pkg::THR_MIN && m1_r <= qcac_pkg::THR_MAX &&
                     m3_r >= qcac_pkg::THR_MIN && m3_r <= qcac_pkg::THR_MAX))
    else $error("motor command out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/qcac_cfg_regs.sv =====
// Configuration register bank for the quad attitude controller.
`default_nettype none
module qcac_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic [qcac_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [qcac_pkg::CfgDataW-1:0] cfg_data,
  output qcac_pkg::cfg_regs_t                regs
);

  qcac_pkg::cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.angle_gain      <= qcac_pkg::ANGLE_GAIN_RST;
      regs_r.integral_gain   <= qcac_pkg::INTEGRAL_GAIN_RST;
      regs_r.integral_limit  <= qcac_pkg::INTEGRAL_LIMIT_RST;
      regs_r.clear_band      <= qcac_pkg::CLEAR_BAND_RST;
      regs_r.pitch_rate_gain <= qcac_pkg::PITCH_GAIN_RST;
      regs_r.roll_rate_gain  <= qcac_pkg::ROLL_GAIN_RST;
      regs_r.yaw_rate_gain   <= qcac_pkg::YAW_GAIN_RST;
      regs_r.manual_select   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        qcac_pkg::REG_ANGLE_GAIN:     regs_r.angle_gain      <= cfg_data[15:0];
        qcac_pkg::REG_INTEGRAL_GAIN:  regs_r.integral_gain   <= cfg_data[15:0];
        qcac_pkg::REG_INTEGRAL_LIMIT: regs_r.integral_limit  <= cfg_data[14:0];
        qcac_pkg::REG_CLEAR_BAND:     regs_r.clear_band      <= cfg_data[13:0];
        qcac_pkg::REG_PITCH_GAIN:     regs_r.pitch_rate_gain <= cfg_data[19:0];
        qcac_pkg::REG_ROLL_GAIN:      regs_r.roll_rate_gain  <= cfg_data[19:0];
        qcac_pkg::REG_YAW_GAIN:       regs_r.yaw_rate_gain   <= cfg_data[19:0];
        qcac_pkg::REG_MANUAL_SELECT:  regs_r.manual_select   <= cfg_data[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign regs = regs_r;

endmodule
`default_nettype wire

// ===== hw/rtl/qcac_mul.sv =====
// Shared signed multiplier with registered product.
`default_nettype none
module qcac_mul (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [qcac_pkg::MulW-1:0]    mul_a,
  input  wire logic signed [qcac_pkg::MulW-1:0]    mul_b,
  output logic signed      [qcac_pkg::ProdW-1:0]   prod
);

  logic signed [qcac_pkg::ProdW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= qcac_pkg::ProdW'(mul_a) * qcac_pkg::ProdW'(mul_b);
    end
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

// ===== tb/quad_cascaded_attitude_controller_tb.sv =====
// Self-checking testbench for the cascaded attitude controller with quad X mixer.
module quad_cascaded_attitude_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 11;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 16;
  localparam int NUM_REGS = 8;
  localparam int NUM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PRESSURE_PHASE = 5;
  localparam int ANGLE_SPAN = 11520;

  localparam longint MOTOR_LO = -3277;
  localparam longint MOTOR_HI = 32768;
  localparam longint IDLE_THROTTLE = 32;
  localparam longint MANUAL_FLOOR = 1638;
  localparam longint ERR_LIM = 4480;
  localparam longint RND_INTEG = 131072;
  localparam longint RND_ANGLE = 512;
  localparam longint RND_RATE = 4096;

  localparam logic [3:0] REG_UNMAPPED = 4'd12;

  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic signed [14:0] roll_angle;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] roll_rate;
    logic signed [15:0] yaw_rate;
    logic signed [14:0] pitch_target;
    logic signed [14:0] roll_target;
    logic signed [15:0] yaw_rate_target;
    logic signed [16:0] throttle;
    logic               armed;
  } imu_sample_t;

  // motor one in slot 0
  typedef logic [3:0][16:0] quad_t;

  typedef struct packed {
    logic        is_write;
    logic [3:0]  idx;
    logic [19:0] data;
    imu_sample_t smp;
    logic        typed;
    quad_t       want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic signed [14:0] in_pitch_angle, in_roll_angle, in_pitch_target, in_roll_target;
  logic signed [15:0] in_pitch_rate, in_roll_rate, in_yaw_rate, in_yaw_rate_target;
  logic signed [16:0] in_throttle;
  logic in_armed_flag;
  logic out_valid, out_ready;
  logic signed [16:0] out_motor_one, out_motor_two, out_motor_three, out_motor_four;
  logic cfg_valid, cfg_ready;
  logic [qcac_pkg::CfgIdxW-1:0] cfg_index;
  logic [qcac_pkg::CfgDataW-1:0] cfg_data;

  qcac_pkg::cfg_regs_t ctl;
  logic signed [15:0] pitch_integ, roll_integ;
  quad_t pending_motors[$];
  row_t plan[$];
  int errors = 0;
  int quiet_cycles = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  int hold_len = 0;
  int pitch_bias = 0, roll_bias = 0, bias_left = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  quad_cascaded_attitude_controller uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pitch_angle(in_pitch_angle),
    .in_roll_angle(in_roll_angle),
    .in_pitch_rate(in_pitch_rate),
    .in_roll_rate(in_roll_rate),
    .in_yaw_rate(in_yaw_rate),
    .in_pitch_target(in_pitch_target),
    .in_roll_target(in_roll_target),
    .in_yaw_rate_target(in_yaw_rate_target),
    .in_throttle(in_throttle),
    .in_armed_flag(in_armed_flag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_motor_one(out_motor_one),
    .out_motor_two(out_motor_two),
    .out_motor_three(out_motor_three),
    .out_motor_four(out_motor_four),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic longint clamp(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic logic signed [15:0] integ_step(longint err, longint held, bit grow);
    longint acc, mag, lim;
    lim = longint'(ctl.integral_limit);
    acc = 0;
    mag = (err < 0) ? -err : err;
    if (grow) acc = held + ((err * longint'(ctl.integral_gain) + RND_INTEG) >>> 18);
    if (mag < longint'(ctl.clear_band)) acc = 0;
    return 16'(clamp(acc, -lim, lim));
  endfunction

  function automatic longint rate_term(longint err, longint gain);
    return (err * gain + RND_RATE) >>> 13;
  endfunction

  // Advances the integrators in controller mode, so call once per accepted request.
  function automatic quad_t predict_motors(imu_sample_t s);
    longint pa, ra, pr, rr, yr, pt, rt, yt, thr, t, pe, re, pref, rref, vp, vr, vy;
    longint mix [4];
    bit grow;
    quad_t q;
    pa = $signed(s.pitch_angle);
    ra = $signed(s.roll_angle);
    pr = $signed(s.pitch_rate);
    rr = $signed(s.roll_rate);
    yr = $signed(s.yaw_rate);
    pt = $signed(s.pitch_target);
    rt = $signed(s.roll_target);
    yt = $signed(s.yaw_rate_target);
    thr = $signed(s.throttle);
    if (ctl.manual_select) begin
      t = (thr > MOTOR_HI) ? MOTOR_HI : thr;
      if (t <= MANUAL_FLOOR) t = MOTOR_LO;
      for (int i = 0; i < 4; i++) mix[i] = t;
    end else begin
      t = clamp(thr, MOTOR_LO, MOTOR_HI);
      grow = s.armed && (t > IDLE_THROTTLE);
      pe = clamp(pt - pa, -ERR_LIM, ERR_LIM);
      re = clamp(rt - ra, -ERR_LIM, ERR_LIM);
      pitch_integ = integ_step(pe, pitch_integ, grow);
      roll_integ = integ_step(re, roll_integ, grow);
      pref = ((pe * longint'(ctl.angle_gain) + RND_ANGLE) >>> 10) + pitch_integ;
      rref = ((re * longint'(ctl.angle_gain) + RND_ANGLE) >>> 10) + roll_integ;
      vp = rate_term(pref - pr, ctl.pitch_rate_gain);
      vr = rate_term(rref - rr, ctl.roll_rate_gain);
      vy = rate_term(yt - yr, ctl.yaw_rate_gain);
      mix[0] = t + vp + vr + vy;
      mix[1] = t + vp - vr - vy;
      mix[2] = t - vp - vr + vy;
      mix[3] = t - vp + vr - vy;
    end
    for (int i = 0; i < 4; i++) q[i] = 17'(clamp(mix[i], MOTOR_LO, MOTOR_HI));
    return q;
  endfunction

  function automatic void apply_reg(logic [3:0] idx, logic [19:0] data);
    case (idx)
      qcac_pkg::REG_ANGLE_GAIN:     ctl.angle_gain = data[15:0];
      qcac_pkg::REG_INTEGRAL_GAIN:  ctl.integral_gain = data[15:0];
      qcac_pkg::REG_INTEGRAL_LIMIT: ctl.integral_limit = data[14:0];
      qcac_pkg::REG_CLEAR_BAND:     ctl.clear_band = data[13:0];
      qcac_pkg::REG_PITCH_GAIN:     ctl.pitch_rate_gain = data;
      qcac_pkg::REG_ROLL_GAIN:      ctl.roll_rate_gain = data;
      qcac_pkg::REG_YAW_GAIN:       ctl.yaw_rate_gain = data;
      qcac_pkg::REG_MANUAL_SELECT:  ctl.manual_select = data[0];
      default: ;
    endcase
  endfunction

  function automatic imu_sample_t mk(int pa, int ra, int pr, int rr, int yr,
                                     int pt, int rt, int yt, int thr, bit arm);
    imu_sample_t s;
    s.pitch_angle = 15'(pa);
    s.roll_angle = 15'(ra);
    s.pitch_rate = 16'(pr);
    s.roll_rate = 16'(rr);
    s.yaw_rate = 16'(yr);
    s.pitch_target = 15'(pt);
    s.roll_target = 15'(rt);
    s.yaw_rate_target = 16'(yt);
    s.throttle = 17'(thr);
    s.armed = arm;
    return s;
  endfunction

  // typed rows carry the same value on all four motors
  function automatic void plan_item(imu_sample_t s, bit typed, int motors);
    row_t r;
    r = '0;
    r.smp = s;
    r.typed = typed;
    r.want = {4{17'(motors)}};
    plan.push_back(r);
  endfunction

  function automatic void plan_write(logic [3:0] idx, logic [19:0] data);
    row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx = idx;
    r.data = data;
    plan.push_back(r);
  endfunction

  function automatic logic [15:0] rate_value();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 1600)) - 800);
  endfunction

  function automatic logic [19:0] random_reg(logic [3:0] idx);
    if ($urandom_range(0, 3) == 0) return 20'($urandom);
    case (idx)
      qcac_pkg::REG_ANGLE_GAIN:     return 20'($urandom_range(0, 4096));
      qcac_pkg::REG_INTEGRAL_GAIN:  return 20'($urandom_range(0, 65535));
      qcac_pkg::REG_INTEGRAL_LIMIT: return 20'($urandom_range(0, 4000));
      qcac_pkg::REG_CLEAR_BAND:     return 20'($urandom_range(0, 200));
      qcac_pkg::REG_MANUAL_SELECT:  return 20'($urandom_range(0, 4) == 0);
      default:                      return 20'($urandom_range(0, 200000));
    endcase
  endfunction

  // Most samples carry an error bias held over runs of samples so the integrators wind up.
  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    logic [159:0] raw;
    int pick, span;
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      s = raw[$bits(imu_sample_t)-1:0];
      return s;
    end
    if (bias_left == 0) begin
      bias_left = $urandom_range(4, 40);
      span = ($urandom_range(0, 3) == 0) ? 24 : 600;
      pitch_bias = int'($urandom_range(0, 2 * span)) - span;
      roll_bias = int'($urandom_range(0, 2 * span)) - span;
    end
    bias_left--;
    s.pitch_angle = 15'(int'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN);
    s.roll_angle = 15'(int'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN);
    s.pitch_target = 15'($signed(s.pitch_angle) + pitch_bias + int'($urandom_range(0, 8)) - 4);
    s.roll_target = 15'($signed(s.roll_angle) + roll_bias + int'($urandom_range(0, 8)) - 4);
    s.pitch_rate = rate_value();
    s.roll_rate = rate_value();
    s.yaw_rate = rate_value();
    s.yaw_rate_target = rate_value();
    pick = $urandom_range(0, 9);
    case (pick)
      0: s.throttle = 17'($urandom);
      1: s.throttle = 17'($urandom_range(29, 35));
      2: s.throttle = 17'($urandom_range(1635, 1641));
      3: s.throttle = $urandom_range(0, 1) ? 17'(MOTOR_HI) : 17'(MOTOR_LO);
      default: s.throttle = 17'($urandom_range(2000, 30000));
    endcase
    s.armed = ($urandom_range(0, 7) != 0);
    return s;
  endfunction

  task automatic report_err(string msg);
    $display("%0t ERROR %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_sample(imu_sample_t s, bit typed, quad_t want);
    int gap;
    quad_t guess;
    gap = 0;
    while (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pitch_angle <= s.pitch_angle;
    in_roll_angle <= s.roll_angle;
    in_pitch_rate <= s.pitch_rate;
    in_roll_rate <= s.roll_rate;
    in_yaw_rate <= s.yaw_rate;
    in_pitch_target <= s.pitch_target;
    in_roll_target <= s.roll_target;
    in_yaw_rate_target <= s.yaw_rate_target;
    in_throttle <= s.throttle;
    in_armed_flag <= s.armed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = predict_motors(s);
    pending_motors.push_back(typed ? want : guess);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [19:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  // every request answers, so an empty queue means the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_motors.size() != 0) @(posedge clk);
  endtask

  task automatic program_phase(int p);
    case (p)
      0: for (int r = 0; r < NUM_REGS; r++) write_reg(4'(r), 20'd0);
      1: begin
        for (int r = 0; r < NUM_REGS - 1; r++) write_reg(4'(r), 20'hFFFFF);
        write_reg(qcac_pkg::REG_MANUAL_SELECT, 20'd0);
      end
      2: begin
        // fast windup against a wide limit
        write_reg(qcac_pkg::REG_ANGLE_GAIN, 20'(qcac_pkg::ANGLE_GAIN_RST));
        write_reg(qcac_pkg::REG_INTEGRAL_GAIN, 20'hFFFF);
        write_reg(qcac_pkg::REG_INTEGRAL_LIMIT, 20'h7FFF);
        write_reg(qcac_pkg::REG_CLEAR_BAND, 20'd0);
        write_reg(qcac_pkg::REG_PITCH_GAIN, 20'(qcac_pkg::PITCH_GAIN_RST));
        write_reg(qcac_pkg::REG_ROLL_GAIN, 20'(qcac_pkg::ROLL_GAIN_RST));
        write_reg(qcac_pkg::REG_YAW_GAIN, 20'(qcac_pkg::YAW_GAIN_RST));
      end
      3: begin
        for (int r = 0; r < NUM_REGS - 1; r++) write_reg(4'(r), random_reg(4'(r)));
        write_reg(qcac_pkg::REG_MANUAL_SELECT, 20'd1);
      end
      default: for (int r = 0; r < NUM_REGS; r++) write_reg(4'(r), random_reg(4'(r)));
    endcase
    cfg_valid <= 1'b0;
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin : sink
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        for (int n = 0; n < hold_len; n++) @(posedge clk);
        hold_len = 0;
      end
      out_ready <= ($urandom_range(0, 99) >= rx_pct);
    end
  end

  always @(posedge clk) begin : monitor
    quad_t got, want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_motors.size() == 0) begin
        report_err("motor result with no request pending");
      end else begin
        want = pending_motors.pop_front();
        got = {out_motor_four, out_motor_three, out_motor_two, out_motor_one};
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== want[i])
            report_err($sformatf("motor %0d got %0d want %0d", i + 1,
                                 $signed(got[i]), $signed(want[i])));
        end
      end
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("quad_cascaded_attitude_controller regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    bit last_write;
    row_t r;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_pitch_angle <= '0;
    in_roll_angle <= '0;
    in_pitch_rate <= '0;
    in_roll_rate <= '0;
    in_yaw_rate <= '0;
    in_pitch_target <= '0;
    in_roll_target <= '0;
    in_yaw_rate_target <= '0;
    in_throttle <= '0;
    in_armed_flag <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    ctl = '{angle_gain: qcac_pkg::ANGLE_GAIN_RST,
            integral_gain: qcac_pkg::INTEGRAL_GAIN_RST,
            integral_limit: qcac_pkg::INTEGRAL_LIMIT_RST,
            clear_band: qcac_pkg::CLEAR_BAND_RST,
            pitch_rate_gain: qcac_pkg::PITCH_GAIN_RST,
            roll_rate_gain: qcac_pkg::ROLL_GAIN_RST,
            yaw_rate_gain: qcac_pkg::YAW_GAIN_RST, manual_select: 1'b0};
    pitch_integ = '0;
    roll_integ = '0;

    // controller mode at reset defaults
    plan_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0);
    plan_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 32768, 1), 1, 32768);
    plan_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 65535, 1), 1, 32768);
    plan_item(mk(0, 0, 0, 0, 0, 0, 0, 0, -65536, 1), 1, -3277);
    plan_item(mk(0, 0, 0, 0, 0, 0, 0, 0, -3277, 1), 1, -3277);
    plan_item(mk(-16384, 16383, 32767, -32768, 32767, 16383, -16384, -32768, 20000, 1), 0, 0);
    for (int k = 0; k < 3; k++) plan_item(mk(0, 0, 0, 0, 0, 4480, -4480, 0, 20000, 1), 0, 0);
    // throttle right at and just above the integrator enable point
    plan_item(mk(0, 0, 0, 0, 0, 4480, -4480, 0, 32, 1), 0, 0);
    plan_item(mk(0, 0, 0, 0, 0, 4480, -4480, 0, 33, 1), 0, 0);
    // error one below and at the clear threshold
    plan_item(mk(100, 100, 0, 0, 0, 118, 81, 0, 20000, 1), 0, 0);
    plan_item(mk(100, 100, 0, 0, 0, 119, 81, 0, 20000, 1), 0, 0);
    plan_item(mk(0, 0, 0, 0, 0, 3000, -3000, 0, 20000, 0), 0, 0);
    plan_item(mk(0, 0, -32768, 32767, -32768, 0, 0, 32767, 16384, 1), 0, 0);
    plan_write(REG_UNMAPPED, 20'hFFFFF);
    plan_item(mk(0, 0, 0, 0, 0, 2000, 1000, 0, 20000, 1), 0, 0);
    plan_write(qcac_pkg::REG_MANUAL_SELECT, 20'd1);
    plan_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 32768, 1), 1, 32768);
    plan_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 65535, 1), 1, 32768);
    plan_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 1638, 1), 1, -3277);
    plan_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 1639, 1), 1, 1639);
    plan_item(mk(0, 0, 0, 0, 0, 0, 0, 0, -65536, 1), 1, -3277);
    plan_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, -3277);
    plan_item(mk(500, -500, 100, 100, 100, -500, 500, 0, -3277, 1), 1, -3277);
    // integrators must have held through manual mode
    plan_write(qcac_pkg::REG_MANUAL_SELECT, 20'd0);
    plan_item(mk(0, 0, 0, 0, 0, 2000, 1000, 0, 20000, 1), 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    tx_pct = 31;
    rx_pct = 31;
    last_write = 1'b0;
    foreach (plan[i]) begin
      r = plan[i];
      if (r.is_write) begin
        if (!last_write) drain();
        write_reg(r.idx, r.data);
      end else begin
        if (last_write) cfg_valid <= 1'b0;
        send_sample(r.smp, r.typed, r.want);
      end
      last_write = r.is_write;
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      program_phase(p);
      case (p % 4)
        0: begin tx_pct = 0; rx_pct = 0; end
        1: begin tx_pct = 71; rx_pct = 0; end
        2: begin tx_pct = 0; rx_pct = 71; end
        default: begin tx_pct = 31; rx_pct = 31; end
      endcase
      if (p == PRESSURE_PHASE) begin
        tx_pct = 0;
        rx_pct = 0;
        hold_len = HOLD_CYCLES;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_sample(random_sample(), 1'b0, '0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("quad_cascaded_attitude_controller regression: pass");
    else
      $display("quad_cascaded_attitude_controller regression: fail");
    $finish;
  end

endmodule
